// File: design/efs_pkg.sv
// Shared types, constants and helper functions of the 3x3 edge filter stream block.
// Depends on nothing; efs_win_cell, efs_ctrl and the top level import this package.
`timescale 1ns / 1ps

package efs_pkg;

  // Frame limits that size the line buffer and the position counters.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Fixed field widths.
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Derived widths.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;
  localparam int HGT_W  = $clog2(MAX_HEIGHT) + 1;
  localparam int IROW_W = HGT_W + 1;
  localparam int SUM_W  = PIX_W + 3;
  localparam int LINE_W = 2 * PIX_W;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // Filter modes and input opcodes.
  localparam logic MODE_EDGE     = 1'b0;
  localparam logic MODE_BRIGHTEN = 1'b1;
  localparam logic OP_PIXEL      = 1'b0;
  localparam logic OP_FLUSH      = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // One column of the 3x3 window, top row being the oldest line.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } pix_col_t;

  // Per-item control decided when the item is accepted.
  typedef struct packed {
    logic             upd;       // edge mode: window and line buffer move
    logic             emit;      // the item produces a result
    logic             last;      // the result closes the frame
    logic             col0;      // item sits in column zero
    logic             zero_pix;  // pixel value is replaced by zero
    logic             m_top;
    logic             m_bot;
    logic             m_left;
    logic             m_right;
    logic [COL_W-1:0] addr;      // line buffer column
  } ctl_t;

  // Width as used by the counters: zero reads as one, large values saturate.
  function automatic logic [WID_W-1:0] eff_width(logic [DIM_W-1:0] raw);
    logic [WID_W-1:0] res;
    if (raw == '0) begin
      res = WID_W'(1);
    end else if (int'(raw) > MAX_WIDTH) begin
      res = WID_W'(MAX_WIDTH);
    end else begin
      res = WID_W'(raw);
    end
    return res;
  endfunction

  // Height as used by the counters, with the same clamping.
  function automatic logic [HGT_W-1:0] eff_height(logic [DIM_W-1:0] raw);
    logic [HGT_W-1:0] res;
    if (raw == '0) begin
      res = HGT_W'(1);
    end else if (int'(raw) > MAX_HEIGHT) begin
      res = HGT_W'(MAX_HEIGHT);
    end else begin
      res = HGT_W'(raw);
    end
    return res;
  endfunction

endpackage

// File: design/efs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; used for the line buffer of the edge filter.
`timescale 1ns / 1ps

module efs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the output holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/efs_win_cell.sv
// One column cell of the 3x3 window: holds three pixels and hands them on.
// Depends on efs_pkg for the column type.
`timescale 1ns / 1ps

module efs_win_cell import efs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     shift_i,
  input  logic     clear_i,
  input  pix_col_t col_i,
  output pix_col_t col_o
);

  pix_col_t col_q;

  // Take the neighbour's column on a shift; a frame end empties the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (clear_i) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// File: design/efs_ctrl.sv
// Position counters of the edge filter: input and result positions in the frame.
// Depends on efs_pkg; decides per accepted item its control word.
`timescale 1ns / 1ps

module efs_ctrl import efs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             opcode_i,
  input  logic             mode_i,
  input  logic [WID_W-1:0] width_i,
  input  logic [HGT_W-1:0] height_i,
  output ctl_t             ctl_o
);

  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [IROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [HGT_W-1:0]  out_row_q, out_row_d;

  logic [WID_W-1:0]  in_col_inc;
  logic [WID_W-1:0]  out_col_inc;
  logic [HGT_W:0]    out_row_inc;
  logic              at_right;
  logic              at_bottom;
  logic              adv_last;
  logic [COL_W-1:0]  adv_col;
  logic [HGT_W-1:0]  adv_row;
  ctl_t              ctl;

  // Next result position, as if a result were produced now.
  always_comb begin
    out_col_inc = {1'b0, out_col_q} + WID_W'(1);
    out_row_inc = {1'b0, out_row_q} + (HGT_W + 1)'(1);
    at_right    = out_col_inc >= width_i;
    at_bottom   = out_row_inc >= {1'b0, height_i};
    adv_last    = at_right && at_bottom;
    if (adv_last) begin
      adv_col = '0;
      adv_row = '0;
    end else if (at_right) begin
      adv_col = '0;
      adv_row = out_row_inc[HGT_W-1:0];
    end else begin
      adv_col = out_col_inc[COL_W-1:0];
      adv_row = out_row_q;
    end
  end

  // Control word and counter updates for the item on offer.
  always_comb begin
    ctl        = '0;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    in_col_inc = {1'b0, in_col_q} + WID_W'(1);
    if (mode_i == MODE_EDGE) begin
      ctl.upd      = 1'b1;
      ctl.addr     = in_col_q;
      ctl.col0     = in_col_q == '0;
      ctl.zero_pix = (opcode_i == OP_FLUSH) || (in_row_q >= IROW_W'(height_i));
      ctl.emit     = (in_row_q > IROW_W'(1)) ||
                     ((in_row_q == IROW_W'(1)) && (in_col_q != '0));
      ctl.m_top    = out_row_q == '0;
      ctl.m_bot    = at_bottom;
      ctl.m_left   = out_col_q == '0;
      ctl.m_right  = at_right;
      if (in_col_inc >= width_i) begin
        in_col_d = '0;
        if (in_row_q != '1) begin
          in_row_d = in_row_q + IROW_W'(1);
        end
      end else begin
        in_col_d = in_col_inc[COL_W-1:0];
      end
      if (ctl.emit) begin
        ctl.last  = adv_last;
        out_col_d = adv_col;
        out_row_d = adv_row;
        if (adv_last) begin
          in_col_d = '0;
          in_row_d = '0;
        end
      end
    end else if (opcode_i == OP_PIXEL) begin
      // Brighten mode only counts results to place the frame end.
      ctl.emit  = 1'b1;
      ctl.last  = adv_last;
      out_col_d = adv_col;
      out_row_d = adv_row;
    end
  end

  // Counters take their next values on every accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (accept_i) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  assign ctl_o = ctl;

  // The frame end in edge mode returns the input position to the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && ctl.upd && ctl.last) |=> (in_col_q == '0 && in_row_q == '0))
    else $error("input position not cleared after the frame end");

  // No edge result is due while the first row is still arriving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.upd && in_row_q == '0) |-> !ctl.emit)
    else $error("edge result scheduled during the first row");

  // A flush in brighten mode never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_i == MODE_BRIGHTEN && opcode_i == OP_FLUSH) |-> !ctl.emit)
    else $error("brighten flush scheduled a result");

endmodule

// File: design/edge_filter_3x3_stream.sv
// Top level of the 3x3 edge filter stream block: configuration registers, line buffer,
// window cells, kernel arithmetic and output register.
// Depends on efs_pkg, efs_ram, efs_win_cell and efs_ctrl.
`timescale 1ns / 1ps

// Usage
// Pixels arrive in raster order on the s_axis channel, one transfer per item; tuser
// marks a flush item, which feeds zero padding to drain the last row. Results leave on
// the m_axis channel, with tlast on the final pixel of a frame.
// Configuration (width, height, mode) is written through the APB port while idle.
// In edge mode the result of a pixel is due width+1 items after that pixel; the first
// width+1 items of a frame give no result. In brighten mode every pixel gives a result
// and a flush gives none.
// An accepted transfer is registered in the window stage; its result is then loaded into
// the output register, which drives m_axis, once the output register is free.
// Throughput: one item per cycle while the receiver takes results, set by the line buffer
// RAM, which is read once per accepted item and written once as the item moves on.
// Reset clears the counters, the window and both stages. The line buffer is not
// cleared; entries not yet written in a frame fall under the border masks.
// When the receiver stalls, the output register holds its result; items that give no
// result still pass, and one more item that gives a result can enter and wait in the
// window stage, after which s_axis_tready_o drops.

module edge_filter_3x3_stream import efs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration port
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic                  pready_o,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PIX_W-1:0]      s_axis_tdata_i,   // [7:0] pixel_in
  input  logic                  s_axis_tuser_i,   // [0] opcode
  // Output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [PIX_W-1:0]      m_axis_tdata_o,   // [7:0] pixel_out
  output logic                  m_axis_tlast_o    // last_of_frame
);

  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic              mode_q;
  logic              cfg_wr;

  logic              accept;
  ctl_t              ctl;

  logic              s1_valid_q;
  ctl_t              s1_ctl_q;
  pix_t              s1_pix_q;
  logic              s1_fwd_q;
  logic [LINE_W-1:0] s1_fwd_data_q;
  logic              s1_moves;
  logic              out_free;

  logic [LINE_W-1:0] line_rdata;
  logic [LINE_W-1:0] line_pair;
  logic [LINE_W-1:0] line_wdata;
  pix_t              v_eff;
  pix_col_t          new_col;
  pix_col_t          cell0_col;
  pix_col_t          cell1_col;
  logic              win_shift;
  logic              win_clear;

  pix_col_t          lc, cc, rc;
  logic [SUM_W-1:0]  sum_n;
  logic [SUM_W-1:0]  cen8;
  logic [SUM_W-1:0]  diff;
  logic [SUM_W:0]    rnd;
  pix_t              edge_val;
  logic [PIX_W+1:0]  tri_val;
  pix_t              bright_val;
  pix_t              result;

  logic              m_valid_q;
  pix_t              m_data_q;
  logic              m_last_q;

  // Configuration registers.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1024);
      height_q <= DIM_W'(1024);
      mode_q   <= MODE_EDGE;
    end else if (cfg_wr) begin
      case (paddr_i[3:2])
        REG_WIDTH:  width_q  <= pwdata_i[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata_i[DIM_W-1:0];
        REG_MODE:   mode_q   <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      REG_WIDTH:  prdata_o = APB_DATA_W'(width_q);
      REG_HEIGHT: prdata_o = APB_DATA_W'(height_q);
      REG_MODE:   prdata_o = APB_DATA_W'(mode_q);
      default:    prdata_o = '0;
    endcase
  end

  // Handshake: the window stage moves unless its result finds the output full.
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s1_moves        = s1_valid_q && (!s1_ctl_q.emit || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_moves;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  efs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (s_axis_tuser_i),
    .mode_i   (mode_q),
    .width_i  (eff_width(width_q)),
    .height_i (eff_height(height_q)),
    .ctl_o    (ctl)
  );

  // Line buffer: upper line in the high byte, lower line in the low byte.
  efs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_moves && s1_ctl_q.upd),
    .waddr_i (s1_ctl_q.addr),
    .wdata_i (line_wdata),
    .re_i    (accept && ctl.upd),
    .raddr_i (ctl.addr),
    .rdata_o (line_rdata)
  );

  // Window stage registers; a read of the column being written takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_fwd_q   <= s1_valid_q && s1_ctl_q.upd && ctl.upd && (ctl.addr == s1_ctl_q.addr);
    end else if (s1_moves) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q      <= ctl;
      s1_pix_q      <= s_axis_tdata_i;
      s1_fwd_data_q <= line_wdata;
    end
  end

  assign line_pair  = s1_fwd_q ? s1_fwd_data_q : line_rdata;
  assign v_eff      = s1_ctl_q.zero_pix ? '0 : s1_pix_q;
  assign line_wdata = {line_pair[PIX_W-1:0], v_eff};
  assign new_col    = '{top: line_pair[LINE_W-1:PIX_W], mid: line_pair[PIX_W-1:0], bot: v_eff};

  // Window as a chain of two column cells; the new column enters at cell 1.
  assign win_shift = s1_moves && s1_ctl_q.upd;
  assign win_clear = win_shift && s1_ctl_q.last;

  efs_win_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (win_shift),
    .clear_i (win_clear),
    .col_i   (new_col),
    .col_o   (cell1_col)
  );

  efs_win_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (win_shift),
    .clear_i (win_clear),
    .col_i   (cell1_col),
    .col_o   (cell0_col)
  );

  // Taps of the result window with the frame borders zeroed. In column zero the due
  // result is the last pixel of the previous row, so the right column is padding.
  always_comb begin
    lc = cell0_col;
    cc = cell1_col;
    rc = s1_ctl_q.col0 ? '0 : new_col;
    if (s1_ctl_q.m_left) begin
      lc = '0;
    end
    if (s1_ctl_q.m_right) begin
      rc = '0;
    end
    if (s1_ctl_q.m_top) begin
      lc.top = '0;
      cc.top = '0;
      rc.top = '0;
    end
    if (s1_ctl_q.m_bot) begin
      lc.bot = '0;
      cc.bot = '0;
      rc.bot = '0;
    end
  end

  // Kernel: eight times the centre less the neighbours, rounded half up by 1/16.
  always_comb begin
    sum_n = SUM_W'(lc.top) + SUM_W'(cc.top) + SUM_W'(rc.top) + SUM_W'(lc.mid)
          + SUM_W'(rc.mid) + SUM_W'(lc.bot) + SUM_W'(cc.bot) + SUM_W'(rc.bot);
    cen8  = {cc.mid, 3'b000};
    diff  = cen8 - sum_n;
    rnd   = {1'b0, diff} + (SUM_W + 1)'(8);
    if (cen8 > sum_n) begin
      edge_val = rnd[SUM_W-:PIX_W];
    end else begin
      edge_val = '0;
    end
  end

  // Brighten: one and a half times the pixel, rounded half up, saturated.
  always_comb begin
    tri_val    = (PIX_W + 2)'(s1_pix_q) + (PIX_W + 2)'({s1_pix_q, 1'b0}) + (PIX_W + 2)'(1);
    bright_val = tri_val[PIX_W+1] ? '1 : tri_val[PIX_W:1];
  end

  assign result = s1_ctl_q.upd ? edge_val : bright_val;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_moves && s1_ctl_q.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_moves && s1_ctl_q.emit) begin
      m_data_q <= result;
      m_last_q <= s1_ctl_q.last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // The window is empty after the frame end in edge mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_clear |=> (cell0_col == '0 && cell1_col == '0))
    else $error("window not cleared after the frame end");

  // No transfer is taken while the window stage holds a stalled item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_moves) |-> !accept)
    else $error("input transfer taken over a stalled window stage");

  // Forwarded line data only ever belongs to an item in the window stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> (s1_valid_q && s1_ctl_q.upd))
    else $error("line forwarding flag without an edge item");

endmodule
